// ===== sv/dss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_pkg: deadman switch supervisor shared types and constants
// LED mode codes, register indexes, limits and the structs passed between
// the supervisor's modules.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int CntW = 16;
  localparam int AdcW = 12;
  localparam int LedW = 3;
  localparam int RegIdxW = 3;
  localparam int RegDataW = 16;

  localparam logic [LedW-1:0] LED_DARK   = 3'd0;
  localparam logic [LedW-1:0] LED_LIT    = 3'd1;
  localparam logic [LedW-1:0] LED_1HZ    = 3'd2;
  localparam logic [LedW-1:0] LED_2HZ    = 3'd3;
  localparam logic [LedW-1:0] LED_4HZ    = 3'd4;
  localparam logic [LedW-1:0] LED_1HZ75  = 3'd5;

  localparam logic [RegIdxW-1:0] REG_ACTIVE_MODE    = 3'd0;
  localparam logic [RegIdxW-1:0] REG_MAX_OPEN       = 3'd1;
  localparam logic [RegIdxW-1:0] REG_MAX_CLOSE      = 3'd2;
  localparam logic [RegIdxW-1:0] REG_WARN_START     = 3'd3;
  localparam logic [RegIdxW-1:0] REG_OPEN_THRESHOLD = 3'd4;

  localparam logic [AdcW-1:0] THRESHOLD_RESET = 12'd1638;

  localparam logic [CntW-1:0] MIN_CLOSE_FOR_WARN = 16'd76;
  localparam logic [CntW:0]   WARN_MARGIN        = 17'd60;
  localparam logic [CntW-1:0] WARN_DEFAULT       = 16'd20;
  localparam logic [CntW-1:0] FAST_WINDOW        = 16'd20;
  localparam logic [CntW-1:0] MEDIUM_WINDOW      = 16'd40;

  typedef struct packed {
    logic            active_mode;
    logic [CntW-1:0] max_open_ticks;
    logic [CntW-1:0] max_close_ticks;
    logic [CntW-1:0] warn_start_ticks;
    logic [AdcW-1:0] open_threshold;
  } cfg_t;

  typedef struct packed {
    logic            last_open;
    logic [CntW-1:0] open_count;
    logic [CntW-1:0] closed_count;
    logic [CntW-1:0] warn_point;
  } state_t;

  typedef struct packed {
    logic            op;
    logic [AdcW-1:0] sample;
    logic            sample_ok;
    logic            past_status;
    logic [LedW-1:0] permit_led;
    logic [LedW-1:0] nonpermit_led;
  } in_t;

  typedef struct packed {
    logic            status;
    logic [LedW-1:0] new_permit_led;
    logic [LedW-1:0] new_nonpermit_led;
  } res_t;

endpackage

// ===== sv/deadman_switch_supervisor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadman_switch_supervisor: deadman safety switch supervisor
// Path: input register, combinational tick logic and state update, then the
// result register, loaded when the output is free. Throughput: one word per
// cycle while the output does not stall.
// Reset: rst clears the state, the registers (threshold to 1638) and both
// valid flags; the block takes words in the cycle after reset.
// ----------------------------------------------------------------------------
module deadman_switch_supervisor
  import dss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [RegIdxW-1:0]  cfg_index,
  input  logic [RegDataW-1:0] cfg_wdata,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // sample[11:0], sample_ok[12], past_status[13], permit_led[16:14],
  // nonpermit_led[19:17], zero fill[23:20]
  input  logic [23:0]         s_axis_tdata,
  // op[0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // status[0], new_permit_led[3:1], new_nonpermit_led[6:4], zero fill[7]
  output logic [7:0]          m_axis_tdata
);

  cfg_t   cfg;
  state_t st;
  state_t st_next;
  in_t    in_reg;
  logic   in_valid;
  res_t   res_next;
  res_t   res_reg;
  logic   out_valid;
  logic   advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !rst && (!in_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_mode      <= 1'b0;
      cfg.max_open_ticks   <= '0;
      cfg.max_close_ticks  <= '0;
      cfg.warn_start_ticks <= '0;
      cfg.open_threshold   <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ACTIVE_MODE:    cfg.active_mode      <= cfg_wdata[0];
        REG_MAX_OPEN:       cfg.max_open_ticks   <= cfg_wdata[CntW-1:0];
        REG_MAX_CLOSE:      cfg.max_close_ticks  <= cfg_wdata[CntW-1:0];
        REG_WARN_START:     cfg.warn_start_ticks <= cfg_wdata[CntW-1:0];
        REG_OPEN_THRESHOLD: cfg.open_threshold   <= cfg_wdata[AdcW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_reg.op            <= s_axis_tuser;
      in_reg.sample        <= s_axis_tdata[11:0];
      in_reg.sample_ok     <= s_axis_tdata[12];
      in_reg.past_status   <= s_axis_tdata[13];
      in_reg.permit_led    <= s_axis_tdata[16:14];
      in_reg.nonpermit_led <= s_axis_tdata[19:17];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  dss_step u_step (
    .cfg     (cfg),
    .st      (st),
    .in_word (in_reg),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, res_reg.new_nonpermit_led, res_reg.new_permit_led,
                          res_reg.status};

endmodule

// ===== sv/dss_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dss_step: one supervision tick
// Computes the result word and the next supervisor state from one input
// word, the current state and the register settings.
// ----------------------------------------------------------------------------
module dss_step
  import dss_pkg::*;
(
  input  cfg_t   cfg,
  input  state_t st,
  input  in_t    in_word,
  output state_t st_next,
  output res_t   res
);

  logic            now_open;
  logic [CntW-1:0] oc_inc;
  logic [CntW-1:0] cc_inc;
  logic [CntW-1:0] open_left;
  logic [CntW-1:0] close_left;
  logic [CntW:0]   warn_limit;
  logic [LedW-1:0] pled;
  logic [LedW-1:0] nled;
  logic            status;

  assign now_open   = in_word.sample > cfg.open_threshold;
  assign oc_inc     = st.open_count + 16'd1;
  assign cc_inc     = st.closed_count + 16'd1;
  assign open_left  = cfg.max_open_ticks - oc_inc;
  assign close_left = cfg.max_close_ticks - cc_inc;
  assign warn_limit = {1'b0, cfg.max_close_ticks} + WARN_MARGIN;

  always_comb begin
    st_next = st;
    pled    = in_word.permit_led;
    nled    = in_word.nonpermit_led;
    status  = 1'b0;
    if (in_word.op) begin
      st_next.last_open = now_open;
      if (cfg.active_mode) begin
        if (cfg.max_close_ticks > MIN_CLOSE_FOR_WARN &&
            {1'b0, cfg.warn_start_ticks} < warn_limit) begin
          st_next.warn_point = cfg.max_close_ticks - cfg.warn_start_ticks;
        end else begin
          st_next.warn_point = cfg.max_close_ticks - WARN_DEFAULT;
        end
        if (now_open) begin
          st_next.open_count   = cfg.max_open_ticks;
          st_next.closed_count = '0;
        end else begin
          st_next.open_count   = '0;
          st_next.closed_count = cfg.max_close_ticks;
        end
      end else begin
        st_next.open_count   = cfg.max_open_ticks;
        st_next.closed_count = '0;
      end
      status = now_open;
    end else if (!in_word.sample_ok) begin
      status = in_word.past_status;
    end else if (now_open == st.last_open) begin
      if (now_open) begin
        st_next.open_count = oc_inc;
        if (st.open_count < cfg.max_open_ticks) begin
          if (open_left < FAST_WINDOW) begin
            if (pled != LED_DARK) begin
              pled = LED_4HZ;
            end else if (nled == LED_1HZ75) begin
              nled = LED_4HZ;
            end
          end
        end else begin
          status = 1'b1;
        end
      end else if (cfg.active_mode) begin
        if (st.closed_count >= cfg.max_close_ticks) begin
          status = 1'b1;
        end else begin
          st_next.closed_count = cc_inc;
          if (cc_inc > st.warn_point || nled == LED_1HZ75) begin
            if (pled == LED_LIT) begin
              pled = LED_1HZ;
            end else if (pled == LED_1HZ || nled == LED_1HZ75) begin
              if (close_left < MEDIUM_WINDOW && pled == LED_1HZ) begin
                pled = LED_2HZ;
              end
            end else if (pled == LED_2HZ || pled == LED_1HZ75) begin
              if (close_left < FAST_WINDOW) begin
                pled = LED_4HZ;
              end
            end else if (nled == LED_1HZ75) begin
              if (close_left < FAST_WINDOW) begin
                nled = LED_4HZ;
              end
            end else if (cc_inc >= cfg.max_close_ticks) begin
              status = 1'b1;
            end
          end
        end
      end
    end else begin
      status = in_word.past_status;
      if (!now_open) begin
        if (pled != LED_DARK) begin
          pled = LED_LIT;
        end
        st_next.last_open = 1'b0;
      end else begin
        if (pled == LED_DARK && nled != LED_1HZ75) begin
          status = 1'b1;
        end else begin
          st_next.last_open = 1'b1;
        end
      end
      st_next.open_count   = '0;
      st_next.closed_count = '0;
    end
  end

  assign res.status            = status;
  assign res.new_permit_led    = pled;
  assign res.new_nonpermit_led = nled;

endmodule

// ===== dv/deadman_switch_supervisor_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadman_switch_supervisor_tb: self-checking bench for the deadman supervisor
// Drives tick and init words through the input stream with random gaps and
// output stalls, and predicts status and LED modes for every accepted word.
// Each result word is compared field by field with the oldest prediction.
// Directed cases come first; then random runs of stable and changing switch
// states under several register settings, extremes included.
// ----------------------------------------------------------------------------
module deadman_switch_supervisor_tb;
  import dss_pkg::*;

  localparam int HalfPeriod = 6;
  localparam int ResetCycles = 5;
  localparam int HoldOffCycles = 150;
  localparam int MaxReported = 10;
  localparam int PhaseItems = 50;
  localparam int CntMax = (1 << CntW) - 1;
  localparam int AdcMax = (1 << AdcW) - 1;
  localparam logic [LedW-1:0] LED_OTHER = 3'd6;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [RegIdxW-1:0]  cfg_index = '0;
  logic [RegDataW-1:0] cfg_wdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [23:0]         s_axis_tdata = '0;
  logic                s_axis_tuser = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;

  logic            cfg_active;
  logic [CntW-1:0] cfg_max_open;
  logic [CntW-1:0] cfg_max_close;
  logic [CntW-1:0] cfg_warn_start;
  logic [AdcW-1:0] cfg_thr;

  logic            held_open;
  logic [CntW-1:0] open_ticks;
  logic [CntW-1:0] closed_ticks;
  logic [CntW-1:0] warn_mark;

  res_t tick_outcomes[$];
  res_t seen;
  res_t want;
  int   mismatch_count = 0;
  bit   tx_throttle = 1'b1;
  bit   rx_throttle = 1'b1;
  bit   rx_hold_req = 1'b0;
  int   rx_stall = 0;

  deadman_switch_supervisor dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #HalfPeriod clk = ~clk;

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 99) < 65) return 0;
    return gap_len();
  endfunction

  function automatic logic [LedW-1:0] rand_led(int pct_1hz75);
    if ($urandom_range(0, 99) < pct_1hz75) return LED_1HZ75;
    return LedW'($urandom_range(0, int'(LED_OTHER)));
  endfunction

  function automatic logic [AdcW-1:0] sample_for(logic open_line);
    int t;
    t = int'(cfg_thr);
    if (open_line && t < AdcMax) begin
      if ($urandom_range(0, 4) == 0) return AdcW'(t + 1);
      return AdcW'($urandom_range(t + 1, AdcMax));
    end
    if ($urandom_range(0, 4) == 0) return AdcW'(t);
    return AdcW'($urandom_range(0, t));
  endfunction

  function automatic in_t word(logic op, int sample, logic ok, logic past,
                               logic [LedW-1:0] pled, logic [LedW-1:0] nled);
    in_t w;
    w.op = op;
    w.sample = AdcW'(sample);
    w.sample_ok = ok;
    w.past_status = past;
    w.permit_led = pled;
    w.nonpermit_led = nled;
    return w;
  endfunction

  function automatic res_t predict_tick(in_t w);
    res_t r;
    logic now_open;
    logic [CntW-1:0] prior;
    int left;
    r.status = 1'b0;
    r.new_permit_led = w.permit_led;
    r.new_nonpermit_led = w.nonpermit_led;
    now_open = w.sample > cfg_thr;
    if (w.op) begin
      held_open = now_open;
      if (cfg_active) begin
        if (cfg_max_close > MIN_CLOSE_FOR_WARN &&
            int'(cfg_warn_start) < int'(cfg_max_close) + int'(WARN_MARGIN))
          warn_mark = cfg_max_close - cfg_warn_start;
        else
          warn_mark = cfg_max_close - WARN_DEFAULT;
        open_ticks = now_open ? cfg_max_open : '0;
        closed_ticks = now_open ? '0 : cfg_max_close;
      end else begin
        open_ticks = cfg_max_open;
        closed_ticks = '0;
      end
      r.status = now_open;
    end else if (!w.sample_ok) begin
      r.status = w.past_status;
    end else if (now_open == held_open) begin
      if (now_open) begin
        prior = open_ticks;
        open_ticks = open_ticks + 1'b1;
        if (prior >= cfg_max_open) begin
          r.status = 1'b1;
        end else if (cfg_max_open - open_ticks < FAST_WINDOW) begin
          if (r.new_permit_led != LED_DARK) r.new_permit_led = LED_4HZ;
          else if (r.new_nonpermit_led == LED_1HZ75) r.new_nonpermit_led = LED_4HZ;
        end
      end else if (cfg_active) begin
        if (closed_ticks >= cfg_max_close) begin
          r.status = 1'b1;
        end else begin
          closed_ticks = closed_ticks + 1'b1;
          left = int'(cfg_max_close) - int'(closed_ticks);
          if (closed_ticks > warn_mark || r.new_nonpermit_led == LED_1HZ75) begin
            if (r.new_permit_led == LED_LIT) begin
              r.new_permit_led = LED_1HZ;
            end else if (r.new_permit_led == LED_1HZ ||
                         r.new_nonpermit_led == LED_1HZ75) begin
              if (left < int'(MEDIUM_WINDOW) && r.new_permit_led == LED_1HZ)
                r.new_permit_led = LED_2HZ;
            end else if (r.new_permit_led == LED_2HZ || r.new_permit_led == LED_1HZ75) begin
              if (left < int'(FAST_WINDOW)) r.new_permit_led = LED_4HZ;
            end else if (r.new_nonpermit_led == LED_1HZ75) begin
              if (left < int'(FAST_WINDOW)) r.new_nonpermit_led = LED_4HZ;
            end else if (closed_ticks >= cfg_max_close) begin
              r.status = 1'b1;
            end
          end
        end
      end
    end else begin
      r.status = w.past_status;
      if (!now_open) begin
        if (r.new_permit_led != LED_DARK) r.new_permit_led = LED_LIT;
        held_open = 1'b0;
      end else if (r.new_permit_led == LED_DARK && r.new_nonpermit_led != LED_1HZ75) begin
        r.status = 1'b1;
      end else begin
        held_open = 1'b1;
      end
      open_ticks = '0;
      closed_ticks = '0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, int exp_val, int act_val);
    mismatch_count++;
    if (mismatch_count <= MaxReported)
      $display("%0t: %s: expected %0d, got %0d", $time, what, exp_val, act_val);
  endtask

  // hold valid after acceptance; the next call or wait_idle decides to drop it
  task automatic send_word(in_t w);
    int gap;
    gap = tx_throttle ? idle_len() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0000, w.nonpermit_led, w.permit_led, w.past_status,
                     w.sample_ok, w.sample};
    s_axis_tuser <= w.op;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    tick_outcomes.push_back(predict_tick(w));
  endtask

  task automatic send_line_tick(logic op, logic open_line);
    send_word(word(op, int'(sample_for(open_line)), $urandom_range(0, 99) >= 6,
                   1'($urandom_range(0, 1)), rand_led(10), rand_led(35)));
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (tick_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic act, int mo, int mc, int ws, int thr);
    logic [RegIdxW-1:0]  idx [5];
    logic [RegDataW-1:0] val [5];
    idx = '{REG_ACTIVE_MODE, REG_MAX_OPEN, REG_MAX_CLOSE, REG_WARN_START,
            REG_OPEN_THRESHOLD};
    val = '{RegDataW'(act), RegDataW'(mo), RegDataW'(mc), RegDataW'(ws),
            RegDataW'(thr)};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cfg_active = act;
    cfg_max_open = CntW'(mo);
    cfg_max_close = CntW'(mc);
    cfg_warn_start = CntW'(ws);
    cfg_thr = AdcW'(thr);
  endtask

  task automatic test_reset_defaults();
    send_word(word(1'b0, 1638, 1'b1, 1'b0, LED_LIT, LED_DARK));
    send_word(word(1'b0, 1639, 1'b1, 1'b0, LED_DARK, LED_DARK));
    send_word(word(1'b0, AdcMax, 1'b0, 1'b1, LED_OTHER, LED_OTHER));
    send_word(word(1'b1, 1639, 1'b0, 1'b0, LED_2HZ, LED_4HZ));
    send_word(word(1'b0, 2000, 1'b1, 1'b0, LED_LIT, LED_1HZ75));
  endtask

  task automatic test_directed_active();
    set_config(1'b1, 2, 80, 10, 2000);
    send_word(word(1'b1, 0, 1'b1, 1'b0, LED_LIT, LED_DARK));
    send_word(word(1'b0, 2000, 1'b1, 1'b0, LED_LIT, LED_DARK));
    send_word(word(1'b0, 2001, 1'b1, 1'b0, LED_LIT, LED_DARK));
    send_word(word(1'b0, AdcMax, 1'b1, 1'b0, LED_LIT, LED_DARK));
    send_word(word(1'b0, AdcMax, 1'b1, 1'b0, LED_DARK, LED_1HZ75));
    send_word(word(1'b0, AdcMax, 1'b1, 1'b1, LED_LIT, LED_DARK));
    send_word(word(1'b0, 2000, 1'b1, 1'b1, LED_2HZ, LED_DARK));
    send_word(word(1'b0, 100, 1'b1, 1'b0, LED_1HZ, LED_1HZ75));
    send_word(word(1'b0, 100, 1'b1, 1'b0, LED_LIT, LED_1HZ75));
    send_word(word(1'b0, 100, 1'b1, 1'b0, LED_1HZ75, LED_1HZ75));
    send_word(word(1'b0, 100, 1'b0, 1'b1, LED_OTHER, LED_OTHER));
    send_word(word(1'b0, 4000, 1'b1, 1'b0, LED_DARK, LED_1HZ75));
  endtask

  task automatic test_config_extremes();
    set_config(1'b0, CntMax, CntMax, CntMax, AdcMax);
    send_word(word(1'b1, AdcMax, 1'b1, 1'b0, LED_DARK, LED_DARK));
    send_word(word(1'b0, AdcMax, 1'b1, 1'b0, LED_LIT, LED_DARK));
    set_config(1'b1, 0, 0, 0, 0);
    send_word(word(1'b1, 0, 1'b1, 1'b0, LED_LIT, LED_DARK));
    send_word(word(1'b0, 0, 1'b1, 1'b0, LED_LIT, LED_DARK));
    send_word(word(1'b1, 1, 1'b1, 1'b0, LED_LIT, LED_DARK));
    send_word(word(1'b0, AdcMax, 1'b1, 1'b0, LED_LIT, LED_DARK));
  endtask

  task automatic test_hold_off();
    set_config(1'b1, 10, 90, 30, THRESHOLD_RESET);
    tx_throttle = 1'b0;
    rx_hold_req <= 1'b1;
    for (int i = 0; i < 40; i++) send_line_tick(i == 0, i >= 20);
    wait_idle();
    tx_throttle = 1'b1;
  endtask

  task automatic test_random_sequences();
    int mo;
    int mc;
    int ws;
    int thr;
    int sent;
    int run_len;
    int flip_pct;
    logic act;
    logic open_line;
    for (int phase = 0; phase < 8; phase++) begin
      act = 1'b1;
      mo = $urandom_range(0, 40);
      mc = $urandom_range(77, 140);
      ws = $urandom_range(0, mc);
      thr = $urandom_range(1, AdcMax - 1);
      case (phase)
        0: begin
          act = 1'b0;
          mc = $urandom_range(0, CntMax);
          ws = $urandom_range(0, CntMax);
          thr = THRESHOLD_RESET;
        end
        2: begin
          mc = $urandom_range(0, int'(MIN_CLOSE_FOR_WARN));
          ws = $urandom_range(0, CntMax);
        end
        3: begin
          ws = mc + int'(WARN_MARGIN) + $urandom_range(0, 1000);
          thr = 0;
        end
        4: begin
          act = 1'b0;
          mo = CntMax;
          mc = CntMax;
          ws = 0;
          thr = AdcMax;
        end
        5: begin
          mo = CntMax;
          mc = CntMax;
          ws = CntMax;
          thr = 0;
        end
        6: begin
          mo = $urandom_range(1, 30);
          mc = $urandom_range(77, 100);
          ws = mc + int'(WARN_MARGIN) - 1 + $urandom_range(0, 1);
        end
        7: begin
          mo = $urandom_range(1, 30);
          mc = $urandom_range(20, 60);
          ws = $urandom_range(0, 30);
        end
        default: ;
      endcase
      set_config(act, mo, mc, ws, thr);
      tx_throttle = (phase != 3);
      rx_throttle <= (phase != 3);
      sent = 0;
      while (sent < PhaseItems) begin
        open_line = 1'($urandom_range(0, 1));
        send_line_tick(1'b1, open_line);
        sent++;
        run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 20);
        flip_pct = (run_len > 20) ? 1 : 10;
        repeat (run_len) begin
          if ($urandom_range(0, 99) < flip_pct) open_line = !open_line;
          send_line_tick($urandom_range(0, 99) >= 97, open_line);
          sent++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold_req) begin
      rx_hold_req <= 1'b0;
      rx_stall <= HoldOffCycles;
      m_axis_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      m_axis_tready <= 1'b0;
    end else if (rx_throttle && $urandom_range(0, 99) < 25) begin
      rx_stall <= gap_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.status = m_axis_tdata[0];
      seen.new_permit_led = m_axis_tdata[3:1];
      seen.new_nonpermit_led = m_axis_tdata[6:4];
      if (tick_outcomes.size() == 0) begin
        report_mismatch("result word with no tick pending", -1, int'(m_axis_tdata));
      end else begin
        want = tick_outcomes.pop_front();
        if (seen.status != want.status)
          report_mismatch("status", int'(want.status), int'(seen.status));
        if (seen.new_permit_led != want.new_permit_led)
          report_mismatch("permit LED", int'(want.new_permit_led),
                          int'(seen.new_permit_led));
        if (seen.new_nonpermit_led != want.new_nonpermit_led)
          report_mismatch("nonpermit LED", int'(want.new_nonpermit_led),
                          int'(seen.new_nonpermit_led));
      end
    end
  end

  initial begin
    cfg_active = 1'b0;
    cfg_max_open = '0;
    cfg_max_close = '0;
    cfg_warn_start = '0;
    cfg_thr = THRESHOLD_RESET;
    held_open = 1'b0;
    open_ticks = '0;
    closed_ticks = '0;
    warn_mark = '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_directed_active();
    test_config_extremes();
    test_hold_off();
    test_random_sequences();
    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
